[rtl/bbq_pkg.sv]
// shared types, codes and widths of the byte budget batch queue
package bbq_pkg;

  localparam int HANDLE_W  = 16;
  localparam int LEN_W     = 12;
  localparam int BYTES_W   = 24;
  localparam int RECS_W    = 9;
  localparam int FRAMES_W  = 7;
  localparam int CSEL_W    = 3;
  localparam int KIND_W    = 3;
  localparam int STAT_W    = 32;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_ACK  = 3'd0,
    KIND_FRAME     = 3'd1,
    KIND_POP_EMPTY = 3'd2,
    KIND_CLEAR_ACK = 3'd3,
    KIND_COUNTER   = 3'd4
  } kind_t;

  typedef enum logic [CSEL_W-1:0] {
    CSEL_RECORDS     = 3'd0,
    CSEL_BYTES       = 3'd1,
    CSEL_PEAK        = 3'd2,
    CSEL_OVR_RECORDS = 3'd3,
    CSEL_OVR_BYTES   = 3'd4,
    CSEL_PUSHED      = 3'd5,
    CSEL_POPPED      = 3'd6
  } csel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // one ring entry: frame handle, length and batch-end mark
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
    logic                batch_end;
  } entry_t;

endpackage

[rtl/bbq_in_if.sv]
// input item channel of the byte budget batch queue
interface bbq_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     op;
  logic [bbq_pkg::HANDLE_W-1:0]   frame_handle;
  logic [bbq_pkg::LEN_W-1:0]      frame_len;
  logic                           batch_first;
  logic                           batch_last;
  logic [bbq_pkg::BYTES_W-1:0]    batch_bytes;
  logic [bbq_pkg::RECS_W-1:0]     batch_records;
  logic [bbq_pkg::FRAMES_W-1:0]   max_frames;
  logic [bbq_pkg::BYTES_W-1:0]    max_bytes;
  logic [bbq_pkg::CSEL_W-1:0]     counter_sel;

  modport source (
    output valid, op, frame_handle, frame_len, batch_first, batch_last,
           batch_bytes, batch_records, max_frames, max_bytes, counter_sel,
    input  ready
  );
  modport sink (
    input  valid, op, frame_handle, frame_len, batch_first, batch_last,
           batch_bytes, batch_records, max_frames, max_bytes, counter_sel,
    output ready
  );
endinterface

[rtl/bbq_out_if.sv]
// result item channel of the byte budget batch queue
interface bbq_out_if;
  logic                           valid;
  logic                           ready;
  logic [bbq_pkg::KIND_W-1:0]     kind;
  logic                           accepted;
  logic                           schedule_drain;
  logic [bbq_pkg::HANDLE_W-1:0]   out_handle;
  logic [bbq_pkg::LEN_W-1:0]      out_len;
  logic                           last;
  logic [bbq_pkg::STAT_W-1:0]     counter_value;
  logic                           drain_pending;

  modport source (
    output valid, kind, accepted, schedule_drain, out_handle, out_len, last,
           counter_value, drain_pending,
    input  ready
  );
  modport sink (
    input  valid, kind, accepted, schedule_drain, out_handle, out_len, last,
           counter_value, drain_pending,
    output ready
  );
endinterface

[rtl/bbq_ring.sv]
// frame ring storage: one write port, one read port with registered data
module bbq_ring #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  bbq_pkg::entry_t   wdata,
  input  logic [AW-1:0]     raddr,
  output bbq_pkg::entry_t   rdata
);

  bbq_pkg::entry_t mem [DEPTH];
  bbq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/byte_budget_batch_handoff_queue.sv]
// byte_budget_batch_handoff_queue: frame queue with a byte budget, batch admission
// and statistics counters
//
// in_if carries one item per handshake: push frame, pop, clear or counter read.
// out_if carries the results through a single output register; an item is taken
// only when that register is empty or its result leaves in the same cycle.
// A push, clear or counter read gives one result in the cycle after acceptance;
// these run back to back at one item per cycle while the receiver keeps up.
// A pop first walks the ring from the head through the memory read port, one
// entry a cycle, to find how many frames n fit the limits, then hands out the
// n frames one per cycle while the receiver takes them, or a single empty
// result, as also for a zero frame or byte limit. A scanning pop holds the input
// through the scan and the hand-out; the single ring read port serves both in turn.
// When the receiver stalls, the result register holds and a pop waits in
// place; the input is not taken until the register can be loaded.
// Reset clears pointers, counters and flags at once; ring contents are not cleared
// and need no sweep. capacity_bytes resets to 1048576; the user must write it
// through cfg_we / cfg_wdata only while the block is idle; the block does not check.
module byte_budget_batch_handoff_queue #(
  parameter int RING_DEPTH = 256,
  parameter int POP_MAX    = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bbq_in_if.sink                        in_if,
  bbq_out_if.source                     out_if,
  input  logic                          cfg_we,
  input  logic [bbq_pkg::BYTES_W-1:0]   cfg_wdata
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int ADM_W = ((CNT_W > bbq_pkg::RECS_W) ? CNT_W : bbq_pkg::RECS_W) + 1;
  localparam int CMP_W = (CNT_W > bbq_pkg::FRAMES_W) ? CNT_W : bbq_pkg::FRAMES_W;
  localparam int BW    = bbq_pkg::BYTES_W;
  localparam int SW    = bbq_pkg::STAT_W;
  localparam int FW    = bbq_pkg::FRAMES_W;

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a,
                                            input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SW] ? '1 : s[SW-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  bbq_pkg::state_t state_r, state_nxt;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PTR_W-1:0] scan_r, scan_nxt;
  logic [CNT_W-1:0] queued_r, queued_nxt;
  logic [BW-1:0]    qbytes_r, qbytes_nxt;
  logic [BW-1:0]    peak_r, peak_nxt;
  logic [SW-1:0]    ovr_rec_r, ovr_rec_nxt;
  logic [SW-1:0]    ovr_bytes_r, ovr_bytes_nxt;
  logic [SW-1:0]    pushed_r, pushed_nxt;
  logic [SW-1:0]    popped_r, popped_nxt;
  logic             drain_r, drain_nxt;
  logic             admit_r, admit_nxt;
  logic [BW-1:0]    cap_r;
  logic [FW-1:0]    limit_r, limit_nxt;
  logic [BW-1:0]    maxb_r, maxb_nxt;
  logic [BW-1:0]    sum_r, sum_nxt;
  logic [FW-1:0]    n_r, n_nxt;

  // result register
  logic                           out_valid_r;
  logic [bbq_pkg::KIND_W-1:0]     out_kind_r, out_kind_nxt;
  logic                           out_acc_r, out_acc_nxt;
  logic                           out_sd_r, out_sd_nxt;
  logic [bbq_pkg::HANDLE_W-1:0]   out_handle_r, out_handle_nxt;
  logic [bbq_pkg::LEN_W-1:0]      out_len_r, out_len_nxt;
  logic                           out_last_r, out_last_nxt;
  logic [SW-1:0]                  out_cv_r, out_cv_nxt;
  logic                           out_drain_r, out_drain_nxt;
  logic                           out_load;
  logic                           out_free;
  logic                           in_acc;

  // ring port signals
  logic             ring_we;
  logic [PTR_W-1:0] ring_raddr;
  bbq_pkg::entry_t  ring_wdata;
  bbq_pkg::entry_t  ring_rdata;

  // push side
  logic [BW:0]      bytes_sum;
  logic [ADM_W-1:0] rec_sum;
  logic             fits;
  logic             admit_eff;
  logic             store;
  // pop side
  logic [FW-1:0]    limit_in;
  logic [BW:0]      scan_sum;
  logic             take;

  bbq_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (PTR_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (tail_r),
    .wdata (ring_wdata),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  assign out_free    = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == bbq_pkg::ST_IDLE) && out_free;
  assign in_acc      = in_if.valid && in_if.ready;

  assign bytes_sum = {1'b0, qbytes_r} + {1'b0, in_if.batch_bytes};
  assign rec_sum   = ADM_W'(queued_r) + ADM_W'(in_if.batch_records);
  assign fits      = (bytes_sum <= {1'b0, cap_r}) && (rec_sum <= ADM_W'(RING_DEPTH));
  assign admit_eff = in_if.batch_first ? fits : admit_r;
  assign store     = admit_eff && (queued_r < CNT_W'(RING_DEPTH));

  assign limit_in  = (in_if.max_frames > FW'(POP_MAX)) ? FW'(POP_MAX) : in_if.max_frames;
  assign scan_sum  = {1'b0, sum_r} + (BW + 1)'(ring_rdata.len);
  assign take      = (n_r < limit_r) && (CMP_W'(n_r) < CMP_W'(queued_r))
                     && (scan_sum <= {1'b0, maxb_r});

  assign ring_wdata.handle    = in_if.frame_handle;
  assign ring_wdata.len       = in_if.frame_len;
  assign ring_wdata.batch_end = in_if.batch_last;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    scan_nxt       = scan_r;
    queued_nxt     = queued_r;
    qbytes_nxt     = qbytes_r;
    peak_nxt       = peak_r;
    ovr_rec_nxt    = ovr_rec_r;
    ovr_bytes_nxt  = ovr_bytes_r;
    pushed_nxt     = pushed_r;
    popped_nxt     = popped_r;
    drain_nxt      = drain_r;
    admit_nxt      = admit_r;
    limit_nxt      = limit_r;
    maxb_nxt       = maxb_r;
    sum_nxt        = sum_r;
    n_nxt          = n_r;
    ring_we        = 1'b0;
    ring_raddr     = head_r;
    out_load       = 1'b0;
    out_kind_nxt   = bbq_pkg::KIND_PUSH_ACK;
    out_acc_nxt    = 1'b0;
    out_sd_nxt     = 1'b0;
    out_handle_nxt = '0;
    out_len_nxt    = '0;
    out_last_nxt   = 1'b1;
    out_cv_nxt     = '0;
    out_drain_nxt  = drain_r;

    unique case (state_r)
      bbq_pkg::ST_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          unique case (bbq_pkg::op_t'(in_if.op))
            bbq_pkg::OP_PUSH: begin
              if (in_if.batch_first) begin
                if (fits) begin
                  qbytes_nxt = bytes_sum[BW-1:0];
                  if (bytes_sum[BW-1:0] > peak_r) begin
                    peak_nxt = bytes_sum[BW-1:0];
                  end
                  pushed_nxt = sat_add(pushed_r, SW'(1));
                end else begin
                  ovr_rec_nxt   = sat_add(ovr_rec_r, SW'(in_if.batch_records));
                  ovr_bytes_nxt = sat_add(ovr_bytes_r, SW'(in_if.batch_bytes));
                end
              end
              if (store) begin
                ring_we    = 1'b1;
                tail_nxt   = ptr_inc(tail_r);
                queued_nxt = queued_r + 1'b1;
                drain_nxt  = 1'b1;
              end
              admit_nxt     = admit_eff && !in_if.batch_last;
              out_kind_nxt  = bbq_pkg::KIND_PUSH_ACK;
              out_acc_nxt   = store;
              out_sd_nxt    = store && !drain_r;
              out_drain_nxt = drain_r || store;
            end
            bbq_pkg::OP_POP: begin
              if (limit_in == '0 || in_if.max_bytes == '0) begin
                out_kind_nxt = bbq_pkg::KIND_POP_EMPTY;
              end else begin
                // the result comes later, after the scan
                out_load  = 1'b0;
                state_nxt = bbq_pkg::ST_SCAN;
                limit_nxt = limit_in;
                maxb_nxt  = in_if.max_bytes;
                sum_nxt   = '0;
                n_nxt     = '0;
                scan_nxt  = head_r;
              end
            end
            bbq_pkg::OP_CLEAR: begin
              head_nxt      = '0;
              tail_nxt      = '0;
              queued_nxt    = '0;
              qbytes_nxt    = '0;
              peak_nxt      = '0;
              ovr_rec_nxt   = '0;
              ovr_bytes_nxt = '0;
              pushed_nxt    = '0;
              popped_nxt    = '0;
              drain_nxt     = 1'b0;
              admit_nxt     = 1'b0;
              out_kind_nxt  = bbq_pkg::KIND_CLEAR_ACK;
              out_drain_nxt = 1'b0;
            end
            bbq_pkg::OP_READ: begin
              out_kind_nxt = bbq_pkg::KIND_COUNTER;
              case (in_if.counter_sel)
                bbq_pkg::CSEL_RECORDS:     out_cv_nxt = SW'(queued_r);
                bbq_pkg::CSEL_BYTES:       out_cv_nxt = SW'(qbytes_r);
                bbq_pkg::CSEL_PEAK:        out_cv_nxt = SW'(peak_r);
                bbq_pkg::CSEL_OVR_RECORDS: out_cv_nxt = ovr_rec_r;
                bbq_pkg::CSEL_OVR_BYTES:   out_cv_nxt = ovr_bytes_r;
                bbq_pkg::CSEL_PUSHED:      out_cv_nxt = pushed_r;
                bbq_pkg::CSEL_POPPED:      out_cv_nxt = popped_r;
                default:                   out_cv_nxt = '0;
              endcase
            end
          endcase
        end
      end

      // ring_rdata holds the entry at scan_r
      bbq_pkg::ST_SCAN: begin
        if (take) begin
          n_nxt      = n_r + 1'b1;
          sum_nxt    = scan_sum[BW-1:0];
          scan_nxt   = ptr_inc(scan_r);
          ring_raddr = ptr_inc(scan_r);
        end else begin
          state_nxt  = bbq_pkg::ST_EMIT;
          ring_raddr = head_r;
        end
      end

      // ring_rdata holds the entry at head_r; n_r frames still to go
      bbq_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (n_r == '0) begin
            out_kind_nxt = bbq_pkg::KIND_POP_EMPTY;
            if (queued_r == '0) begin
              drain_nxt = 1'b0;
            end
            out_drain_nxt = (queued_r != '0) && drain_r;
            state_nxt     = bbq_pkg::ST_IDLE;
          end else begin
            out_kind_nxt   = bbq_pkg::KIND_FRAME;
            out_handle_nxt = ring_rdata.handle;
            out_len_nxt    = ring_rdata.len;
            out_last_nxt   = (n_r == FW'(1));
            out_drain_nxt  = CMP_W'(queued_r) != CMP_W'(n_r);
            head_nxt       = ptr_inc(head_r);
            ring_raddr     = ptr_inc(head_r);
            queued_nxt     = queued_r - 1'b1;
            qbytes_nxt     = (BW'(ring_rdata.len) > qbytes_r) ? '0
                             : qbytes_r - BW'(ring_rdata.len);
            if (ring_rdata.batch_end) begin
              popped_nxt = sat_add(popped_r, SW'(1));
            end
            n_nxt = n_r - 1'b1;
            if (n_r == FW'(1)) begin
              if (queued_r == CNT_W'(1)) begin
                drain_nxt = 1'b0;
              end
              state_nxt = bbq_pkg::ST_IDLE;
            end
          end
        end
      end

      default: state_nxt = bbq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bbq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      queued_r    <= '0;
      qbytes_r    <= '0;
      peak_r      <= '0;
      ovr_rec_r   <= '0;
      ovr_bytes_r <= '0;
      pushed_r    <= '0;
      popped_r    <= '0;
      drain_r     <= 1'b0;
      admit_r     <= 1'b0;
      n_r         <= '0;
      cap_r       <= BW'(1048576);
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      queued_r    <= queued_nxt;
      qbytes_r    <= qbytes_nxt;
      peak_r      <= peak_nxt;
      ovr_rec_r   <= ovr_rec_nxt;
      ovr_bytes_r <= ovr_bytes_nxt;
      pushed_r    <= pushed_nxt;
      popped_r    <= popped_nxt;
      drain_r     <= drain_nxt;
      admit_r     <= admit_nxt;
      n_r         <= n_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pop working registers and result payload
  always_ff @(posedge clk) begin
    scan_r  <= scan_nxt;
    limit_r <= limit_nxt;
    maxb_r  <= maxb_nxt;
    sum_r   <= sum_nxt;
    if (out_load) begin
      out_kind_r   <= out_kind_nxt;
      out_acc_r    <= out_acc_nxt;
      out_sd_r     <= out_sd_nxt;
      out_handle_r <= out_handle_nxt;
      out_len_r    <= out_len_nxt;
      out_last_r   <= out_last_nxt;
      out_cv_r     <= out_cv_nxt;
      out_drain_r  <= out_drain_nxt;
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.kind           = out_kind_r;
  assign out_if.accepted       = out_acc_r;
  assign out_if.schedule_drain = out_sd_r;
  assign out_if.out_handle     = out_handle_r;
  assign out_if.out_len        = out_len_r;
  assign out_if.last           = out_last_r;
  assign out_if.counter_value  = out_cv_r;
  assign out_if.drain_pending  = out_drain_r;

  // drain flag tracks a non-empty ring
  a_drain_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r == (queued_r != '0))
    else $error("drain flag out of step with ring fill");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    queued_r <= CNT_W'(RING_DEPTH))
    else $error("ring fill beyond depth");

  a_emit_within_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bbq_pkg::ST_EMIT) |-> (CMP_W'(n_r) <= CMP_W'(queued_r)))
    else $error("pop would hand out more frames than held");

  a_scan_within_budget: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bbq_pkg::ST_SCAN) |-> (sum_r <= maxb_r && n_r <= limit_r))
    else $error("pop scan went past its limits");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != bbq_pkg::ST_IDLE) |-> !in_if.ready)
    else $error("item taken during a pop");

endmodule

[sim/testbench.sv]
// self-checking bench for the bbq: directed and random traffic against a scoreboard
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_N   = 256;
  localparam int POP_N    = 64;
  localparam int HANDLE_W = bbq_pkg::HANDLE_W;
  localparam int LEN_W    = bbq_pkg::LEN_W;
  localparam int BYTES_W  = bbq_pkg::BYTES_W;
  localparam int RECS_W   = bbq_pkg::RECS_W;
  localparam int FRAMES_W = bbq_pkg::FRAMES_W;
  localparam int CSEL_W   = bbq_pkg::CSEL_W;
  localparam int STAT_W   = bbq_pkg::STAT_W;
  localparam logic [CSEL_W-1:0] CSEL_SPARE = 3'd7;

  typedef struct packed {
    bbq_pkg::op_t        op;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
    logic                first;
    logic                lastf;
    logic [BYTES_W-1:0]  bbytes;
    logic [RECS_W-1:0]   brecs;
    logic [FRAMES_W-1:0] maxf;
    logic [BYTES_W-1:0]  maxb;
    logic [CSEL_W-1:0]   sel;
  } req_t;

  typedef struct packed {
    bbq_pkg::kind_t      kind;
    logic                accepted;
    logic                schedule_drain;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
    logic                last;
    logic [STAT_W-1:0]   count;
    logic                pending;
  } res_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [BYTES_W-1:0] cfg_wdata;
  logic calm;

  bbq_in_if  req_ch ();
  bbq_out_if res_ch ();

  byte_budget_batch_handoff_queue #(
    .RING_DEPTH (RING_N),
    .POP_MAX    (POP_N)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (req_ch),
    .out_if    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // mirror of the queue state
  bbq_pkg::entry_t   ring_store [RING_N];
  int unsigned       head_ix;
  int unsigned       tail_ix;
  int unsigned       held_frames;
  logic [BYTES_W-1:0] held_bytes;
  logic [BYTES_W-1:0] peak_held;
  logic [STAT_W-1:0] lost_frames;
  logic [STAT_W-1:0] lost_bytes;
  logic [STAT_W-1:0] batches_in;
  logic [STAT_W-1:0] batches_out;
  logic              drain_due;
  logic              in_batch;
  logic [BYTES_W-1:0] budget;

  req_t req_backlog [$];
  res_t awaited [$];
  req_t on_bus;
  int   fault_count;

  function automatic logic [STAT_W-1:0] sat_sum(logic [STAT_W-1:0] a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void add_req(req_t r);
    req_backlog = {req_backlog, r};
  endfunction

  function automatic void add_want(res_t o);
    awaited = {awaited, o};
  endfunction

  function automatic void wipe_queue();
    head_ix     = 0;
    tail_ix     = 0;
    held_frames = 0;
    held_bytes  = '0;
    peak_held   = '0;
    lost_frames = '0;
    lost_bytes  = '0;
    batches_in  = '0;
    batches_out = '0;
    drain_due   = 1'b0;
    in_batch    = 1'b0;
  endfunction

  // works out the results of one accepted item and files them in order
  function automatic void queue_outcome(req_t r);
    res_t            o;
    res_t            frames_out [$];
    bbq_pkg::entry_t e;
    int unsigned     cap_n;
    longint unsigned span;
    logic            stored;
    logic            raised;
    o = '0;
    o.last = 1'b1;
    stored = 1'b0;
    raised = 1'b0;
    span = 0;
    case (r.op)
      bbq_pkg::OP_PUSH: begin
        if (r.first) begin
          if (longint'(held_bytes) + r.bbytes <= longint'(budget) &&
              held_frames + r.brecs <= RING_N) begin
            in_batch = 1'b1;
            held_bytes = held_bytes + r.bbytes;
            if (held_bytes > peak_held) peak_held = held_bytes;
            batches_in = sat_sum(batches_in, 1);
          end else begin
            in_batch = 1'b0;
            lost_frames = sat_sum(lost_frames, r.brecs);
            lost_bytes = sat_sum(lost_bytes, r.bbytes);
          end
        end
        if (in_batch && held_frames < RING_N) begin
          e.handle = r.handle;
          e.len = r.len;
          e.batch_end = r.lastf;
          ring_store[tail_ix] = e;
          tail_ix = (tail_ix + 1) % RING_N;
          held_frames++;
          stored = 1'b1;
          if (!drain_due) begin
            drain_due = 1'b1;
            raised = 1'b1;
          end
        end
        if (r.lastf) in_batch = 1'b0;
        o.kind = bbq_pkg::KIND_PUSH_ACK;
        o.accepted = stored;
        o.schedule_drain = raised;
        o.pending = drain_due;
        add_want(o);
      end
      bbq_pkg::OP_POP: begin
        cap_n = (r.maxf > POP_N) ? POP_N : r.maxf;
        if (cap_n != 0 && r.maxb != 0) begin
          while (frames_out.size() < cap_n && held_frames > 0) begin
            e = ring_store[head_ix];
            if (span + e.len > r.maxb) break;
            span += e.len;
            head_ix = (head_ix + 1) % RING_N;
            held_frames--;
            held_bytes = (e.len > held_bytes) ? '0 : held_bytes - e.len;
            if (e.batch_end) batches_out = sat_sum(batches_out, 1);
            o.kind = bbq_pkg::KIND_FRAME;
            o.handle = e.handle;
            o.len = e.len;
            o.last = 1'b0;
            frames_out = {frames_out, o};
          end
          if (held_frames == 0) drain_due = 1'b0;
        end
        if (frames_out.size() == 0) begin
          o = '0;
          o.kind = bbq_pkg::KIND_POP_EMPTY;
          o.last = 1'b1;
          o.pending = drain_due;
          add_want(o);
        end else begin
          frames_out[frames_out.size() - 1].last = 1'b1;
          foreach (frames_out[k]) begin
            frames_out[k].pending = drain_due;
            add_want(frames_out[k]);
          end
        end
      end
      bbq_pkg::OP_CLEAR: begin
        wipe_queue();
        o.kind = bbq_pkg::KIND_CLEAR_ACK;
        add_want(o);
      end
      bbq_pkg::OP_READ: begin
        case (r.sel)
          bbq_pkg::CSEL_RECORDS:     o.count = 32'(held_frames);
          bbq_pkg::CSEL_BYTES:       o.count = 32'(held_bytes);
          bbq_pkg::CSEL_PEAK:        o.count = 32'(peak_held);
          bbq_pkg::CSEL_OVR_RECORDS: o.count = lost_frames;
          bbq_pkg::CSEL_OVR_BYTES:   o.count = lost_bytes;
          bbq_pkg::CSEL_PUSHED:      o.count = batches_in;
          bbq_pkg::CSEL_POPPED:      o.count = batches_out;
          default:                   o.count = '0;
        endcase
        o.kind = bbq_pkg::KIND_COUNTER;
        o.pending = drain_due;
        add_want(o);
      end
    endcase
  endfunction

  // every field random within its range; builders below override what matters
  function automatic req_t blank_req(bbq_pkg::op_t op);
    req_t r;
    r.op     = op;
    r.handle = HANDLE_W'($urandom);
    r.len    = LEN_W'($urandom);
    r.first  = 1'($urandom);
    r.lastf  = 1'($urandom);
    r.bbytes = BYTES_W'($urandom);
    r.brecs  = RECS_W'($urandom_range(1, 256));
    r.maxf   = FRAMES_W'($urandom_range(0, 64));
    r.maxb   = BYTES_W'($urandom);
    r.sel    = CSEL_W'($urandom_range(0, 7));
    return r;
  endfunction

  function automatic req_t frame_req(logic [HANDLE_W-1:0] h, logic [LEN_W-1:0] len,
                                     logic first, logic lastf,
                                     logic [BYTES_W-1:0] bb, logic [RECS_W-1:0] br);
    req_t r;
    r = blank_req(bbq_pkg::OP_PUSH);
    r.handle = h;
    r.len = len;
    r.first = first;
    r.lastf = lastf;
    r.bbytes = bb;
    r.brecs = br;
    return r;
  endfunction

  function automatic req_t pop_req(logic [FRAMES_W-1:0] mf, logic [BYTES_W-1:0] mb);
    req_t r;
    r = blank_req(bbq_pkg::OP_POP);
    r.maxf = mf;
    r.maxb = mb;
    return r;
  endfunction

  function automatic req_t read_req(logic [CSEL_W-1:0] sel);
    req_t r;
    r = blank_req(bbq_pkg::OP_READ);
    r.sel = sel;
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 12) return '0;
    if (p < 80) return LEN_W'($urandom_range(1, 700));
    return LEN_W'($urandom_range(0, 4095));
  endfunction

  // one batch as a run of frames; a flawed one lies about its totals or never ends
  task automatic frame_run(int frames, bit honest);
    logic [LEN_W-1:0] lens [$];
    longint unsigned  sum;
    int               flaw;
    req_t             r;
    sum = 0;
    for (int k = 0; k < frames; k++) begin
      lens = {lens, pick_len()};
      sum += lens[k];
    end
    flaw = honest ? 0 : $urandom_range(1, 3);
    for (int k = 0; k < frames; k++) begin
      r = frame_req(HANDLE_W'($urandom), lens[k], k == 0, k == frames - 1 && flaw != 3,
                    sum[BYTES_W-1:0], RECS_W'(frames));
      if (flaw == 1) r.bbytes = BYTES_W'($urandom);
      if (flaw == 2) r.brecs = RECS_W'($urandom_range(1, 256));
      add_req(r);
    end
  endtask

  task automatic random_traffic(int items);
    int   added;
    int   pick;
    int   frames;
    int   p;
    logic [FRAMES_W-1:0] mf;
    logic [BYTES_W-1:0]  mb;
    req_t r;
    added = 0;
    while (added < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 48) begin
        frames = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
        frame_run(frames, $urandom_range(0, 99) < 85);
        added += frames;
      end else begin
        if (pick < 76) begin
          p = $urandom_range(0, 19);
          mf = (p == 0) ? '0 : (p < 3) ? FRAMES_W'(POP_N) : FRAMES_W'($urandom_range(1, 64));
          p = $urandom_range(0, 19);
          mb = (p == 0) ? '0 : (p < 7) ? BYTES_W'($urandom) : BYTES_W'($urandom_range(1, 8000));
          r = pop_req(mf, mb);
        end else if (pick < 82) begin
          // frame outside any batch
          r = blank_req(bbq_pkg::OP_PUSH);
          r.first = 1'b0;
        end else if (pick < 92) begin
          r = blank_req(bbq_pkg::OP_READ);
        end else if (pick < 94) begin
          r = blank_req(bbq_pkg::OP_CLEAR);
        end else begin
          r = blank_req(bbq_pkg::OP_PUSH);
        end
        add_req(r);
        added++;
      end
    end
  endtask

  // fills the ring with one batch whose totals undercount, then drains it
  task automatic ring_fill();
    add_req(blank_req(bbq_pkg::OP_CLEAR));
    for (int k = 0; k < RING_N + 2; k++) begin
      add_req(frame_req(HANDLE_W'($urandom), LEN_W'($urandom_range(0, 120)),
                        k == 0, k == RING_N + 1, 24'd1000, 9'd256));
    end
    add_req(frame_req(16'h0BAD, 12'd1, 1'b1, 1'b1, 24'd1, 9'd1));
    add_req(read_req(bbq_pkg::CSEL_RECORDS));
    add_req(read_req(bbq_pkg::CSEL_OVR_RECORDS));
    add_req(pop_req(7'd64, 24'd500));
    add_req(read_req(bbq_pkg::CSEL_BYTES));
    for (int k = 0; k < 5; k++) add_req(pop_req(7'd64, 24'hFFFFFF));
    add_req(read_req(bbq_pkg::CSEL_POPPED));
    add_req(read_req(bbq_pkg::CSEL_PEAK));
  endtask

  task automatic set_budget(logic [BYTES_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    budget = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (req_backlog.size() != 0 || req_ch.valid || awaited.size() != 0);
    repeat (12) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic log_fault(string why, res_t want, res_t got);
    if (fault_count < 10) begin
      $display("%0t %s: want kind=%0d acc=%0d sched=%0d handle=%h len=%0d last=%0d",
               $realtime, why, want.kind, want.accepted, want.schedule_drain, want.handle,
               want.len, want.last, " count=%0d pending=%0d", want.count, want.pending);
      $display("%0t %s: got  kind=%0d acc=%0d sched=%0d handle=%h len=%0d last=%0d",
               $realtime, why, got.kind, got.accepted, got.schedule_drain, got.handle,
               got.len, got.last, " count=%0d pending=%0d", got.count, got.pending);
    end
    fault_count++;
  endtask

  // sender: one item on the bus at a time, held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) queue_outcome(on_bus);
      if (!req_ch.valid || req_ch.ready) begin
        if (req_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 38)) begin
          on_bus = req_backlog[0];
          req_backlog.delete(0);
          req_ch.valid         <= 1'b1;
          req_ch.op            <= on_bus.op;
          req_ch.frame_handle  <= on_bus.handle;
          req_ch.frame_len     <= on_bus.len;
          req_ch.batch_first   <= on_bus.first;
          req_ch.batch_last    <= on_bus.lastf;
          req_ch.batch_bytes   <= on_bus.bbytes;
          req_ch.batch_records <= on_bus.brecs;
          req_ch.max_frames    <= on_bus.maxf;
          req_ch.max_bytes     <= on_bus.maxb;
          req_ch.counter_sel   <= on_bus.sel;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random back-pressure, each result checked against the oldest expectation
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind           = bbq_pkg::kind_t'(res_ch.kind);
        got.accepted       = res_ch.accepted;
        got.schedule_drain = res_ch.schedule_drain;
        got.handle         = res_ch.out_handle;
        got.len            = res_ch.out_len;
        got.last           = res_ch.last;
        got.count          = res_ch.counter_value;
        got.pending        = res_ch.drain_pending;
        if (awaited.size() == 0) begin
          log_fault("item with nothing awaited", '0, got);
        end else begin
          want = awaited[0];
          awaited.delete(0);
          if (got.kind !== want.kind || got.accepted !== want.accepted ||
              got.schedule_drain !== want.schedule_drain || got.handle !== want.handle ||
              got.len !== want.len || got.last !== want.last ||
              got.count !== want.count || got.pending !== want.pending)
            log_fault("result differs", want, got);
        end
      end
      res_ch.ready <= calm || $urandom_range(0, 99) >= 38;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    calm = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.op = '0;
    req_ch.frame_handle = '0;
    req_ch.frame_len = '0;
    req_ch.batch_first = 1'b0;
    req_ch.batch_last = 1'b0;
    req_ch.batch_bytes = '0;
    req_ch.batch_records = '0;
    req_ch.max_frames = '0;
    req_ch.max_bytes = '0;
    req_ch.counter_sel = '0;
    res_ch.ready = 1'b0;
    fault_count = 0;
    budget = 24'd1048576;
    wipe_queue();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pop on an empty ring, then admission, drop and stray frames
    add_req(pop_req(7'd64, 24'hFFFFFF));
    add_req(read_req(bbq_pkg::CSEL_RECORDS));
    add_req(frame_req(16'hFFFF, 12'hFFF, 1'b1, 1'b1, 24'd4095, 9'd1));
    add_req(frame_req(16'h0000, 12'd0, 1'b1, 1'b0, 24'hFFFFFF, 9'd3));
    add_req(frame_req(16'h1234, 12'd10, 1'b0, 1'b1, 24'd0, 9'd1));
    add_req(frame_req(16'h2222, 12'd10, 1'b1, 1'b1, 24'd10, 9'd256));
    add_req(frame_req(16'h00AA, 12'd60, 1'b1, 1'b0, 24'd100, 9'd2));
    add_req(frame_req(16'h0055, 12'd40, 1'b0, 1'b1, 24'd0, 9'd1));
    // pop limits: zero frames, zero bytes, one frame, head too big, the rest
    add_req(pop_req(7'd0, 24'hFFFFFF));
    add_req(pop_req(7'd64, 24'd0));
    add_req(pop_req(7'd1, 24'hFFFFFF));
    add_req(pop_req(7'd64, 24'd50));
    add_req(pop_req(7'd64, 24'd100));
    for (int s = 0; s < 7; s++) add_req(read_req(CSEL_W'(s)));
    add_req(read_req(CSEL_SPARE));
    add_req(blank_req(bbq_pkg::OP_CLEAR));
    add_req(read_req(bbq_pkg::CSEL_PEAK));
    add_req(frame_req(16'h8001, 12'd0, 1'b1, 1'b1, 24'd0, 9'd1));
    add_req(pop_req(7'd64, 24'd1));
    wait_quiet();

    set_budget('0);
    random_traffic(40);
    wait_quiet();

    set_budget(24'hFFFFFF);
    calm = 1'b1;
    ring_fill();
    wait_quiet();
    calm = 1'b0;

    set_budget(BYTES_W'($urandom_range(6000, 30000)));
    random_traffic(30);
    wait_quiet();

    if (fault_count == 0 && awaited.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
rtl/bbq_pkg.sv
rtl/bbq_in_if.sv
rtl/bbq_out_if.sv
rtl/bbq_ring.sv
rtl/byte_budget_batch_handoff_queue.sv
sim/testbench.sv
